@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/frt_pkg.sv @@
// Shared types, codes and defaults of the fragment reassembly tracker.
package frt_pkg;

    localparam int PLEN_W = 11;
    localparam int ID_W   = 16;
    localparam int LEN_W  = 11;

    localparam int DEF_MAX_TRANSFER_BYTES = 1024;
    localparam int DEF_HEADER_BYTES       = 8;
    localparam int DEF_QUEUE_DEPTH        = 2;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_RESET_ACK,
        ACT_FAIL_BIG,
        ACT_COMPLETE
    } t_action;

    typedef enum logic [2:0] {
        DROP_NONE,
        DROP_SHORT,
        DROP_FIRST_SEQ,
        DROP_WRONG_MSG,
        DROP_WRONG_SEQ
    } t_drop;

    typedef struct packed {
        logic              too_short;
        logic              reset_ack;
        logic              flag_reset;
        logic              flag_first;
        logic              flag_last;
        logic [PLEN_W-1:0] payload;
        logic [ID_W-1:0]   message_id;
        logic [ID_W-1:0]   sequence_id;
    } t_item;

    typedef struct packed {
        t_action          reply_action;
        t_drop            drop_reason;
        logic             store_enable;
        logic [LEN_W-1:0] store_offset;
        logic [LEN_W-1:0] store_length;
        logic [LEN_W-1:0] message_length;
    } t_result;

endpackage

@@ rtl/fragment_reassembly_tracker_unit.sv @@
// Top level of the fragment reassembly tracker.
// One packet header per cycle is taken while o_ready is high, and one result per header
// is delivered, in order. The front classifies a header in the cycle of its transfer and
// pushes it into a short queue; the back makes the state-dependent decision (message and
// sequence checks, room check, fill update) on the queue head and holds the result in an
// output register, which the header reaches after the queue. A stall on the output side
// fills the queue before o_ready drops. Headers with a reset flag and no payload return a
// reset ack; every other header not too short is checked against the current transfer.
module fragment_reassembly_tracker_unit import frt_pkg::*; #(
    parameter int MAX_TRANSFER_BYTES = DEF_MAX_TRANSFER_BYTES,
    parameter int HEADER_BYTES       = DEF_HEADER_BYTES,
    parameter int QUEUE_DEPTH        = DEF_QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [PLEN_W-1:0] i_packet_len,
    input  logic              i_flag_reset,
    input  logic              i_flag_first,
    input  logic              i_flag_last,
    input  logic [ID_W-1:0]   i_message_id,
    input  logic [ID_W-1:0]   i_sequence_id,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_reply_action,
    output logic [2:0]        o_drop_reason,
    output logic              o_store_enable,
    output logic [LEN_W-1:0]  o_store_offset,
    output logic [LEN_W-1:0]  o_store_length,
    output logic [LEN_W-1:0]  o_message_length
);

    logic    push;
    t_item   push_item;
    logic    queue_ready;
    logic    head_valid;
    t_item   head_item;
    logic    back_ready;
    t_result result;

    frt_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_packet_len  (i_packet_len),
        .i_flag_reset  (i_flag_reset),
        .i_flag_first  (i_flag_first),
        .i_flag_last   (i_flag_last),
        .i_message_id  (i_message_id),
        .i_sequence_id (i_sequence_id),
        .o_push        (push),
        .o_item        (push_item),
        .i_queue_ready (queue_ready)
    );

    frt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (queue_ready),
        .i_pop   (back_ready),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    frt_back #(
        .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (head_valid),
        .i_item       (head_item),
        .o_item_ready (back_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (result)
    );

    assign o_reply_action   = result.reply_action;
    assign o_drop_reason    = result.drop_reason;
    assign o_store_enable   = result.store_enable;
    assign o_store_offset   = result.store_offset;
    assign o_store_length   = result.store_length;
    assign o_message_length = result.message_length;

endmodule

@@ rtl/frt_front.sv @@
// Front end: accepts packet headers and classifies what does not depend on state.
module frt_front import frt_pkg::*; #(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [PLEN_W-1:0] i_packet_len,
    input  logic              i_flag_reset,
    input  logic              i_flag_first,
    input  logic              i_flag_last,
    input  logic [ID_W-1:0]   i_message_id,
    input  logic [ID_W-1:0]   i_sequence_id,
    output logic              o_push,
    output t_item             o_item,
    input  logic              i_queue_ready
);

    localparam logic [PLEN_W-1:0] HDR = PLEN_W'(HEADER_BYTES);

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;

    always_comb begin
        o_item.too_short   = i_packet_len < HDR;
        o_item.reset_ack   = i_flag_reset && (i_packet_len == HDR);
        o_item.flag_reset  = i_flag_reset;
        o_item.flag_first  = i_flag_first;
        o_item.flag_last   = i_flag_last;
        o_item.payload     = i_packet_len - HDR;
        o_item.message_id  = i_message_id;
        o_item.sequence_id = i_sequence_id;
    end

endmodule

@@ rtl/frt_queue.sv @@
// Short FIFO of classified items between front and back.
module frt_queue import frt_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/frt_back.sv @@
// Back end: transfer state, per-packet decision and output register.
module frt_back import frt_pkg::*; #(
    parameter int MAX_TRANSFER_BYTES = DEF_MAX_TRANSFER_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int FILL_W = $clog2(MAX_TRANSFER_BYTES + 1);
    localparam int W      = (FILL_W > PLEN_W) ? FILL_W : PLEN_W;
    localparam logic [W-1:0] MAX_W = W'(MAX_TRANSFER_BYTES);

    logic              r_in_transfer;
    logic [ID_W-1:0]   r_cur_msg;
    logic [ID_W-1:0]   r_exp_seq;
    logic [FILL_W-1:0] r_fill;
    logic              r_out_valid;
    t_result           r_result;

    logic              n_in_transfer;
    logic [ID_W-1:0]   n_cur_msg;
    logic [ID_W-1:0]   n_exp_seq;
    logic [FILL_W-1:0] n_fill;
    t_result           n_result;

    logic              pop;
    logic              go;
    logic [W-1:0]      fill_w;
    logic [W-1:0]      pay_w;
    logic [W-1:0]      room;
    logic [W-1:0]      new_fill;

    assign o_item_ready = !r_out_valid || i_ready;
    assign pop          = i_item_valid && o_item_ready;
    assign o_valid      = r_out_valid;
    assign o_result     = r_result;

    always_comb begin
        n_in_transfer = r_in_transfer;
        n_cur_msg     = r_cur_msg;
        n_exp_seq     = r_exp_seq;
        n_fill        = r_fill;
        go            = 1'b0;
        fill_w        = '0;
        pay_w         = W'(i_item.payload);
        room          = '0;
        new_fill      = '0;
        n_result      = '0;
        n_result.reply_action = ACT_NONE;
        n_result.drop_reason  = DROP_NONE;

        if (i_item.too_short) begin
            n_result.drop_reason = DROP_SHORT;
        end else if (i_item.reset_ack) begin
            n_in_transfer = 1'b0;
            n_cur_msg     = '0;
            n_exp_seq     = '0;
            n_fill        = '0;
            n_result.reply_action = ACT_RESET_ACK;
        end else begin
            if (i_item.flag_reset) begin
                n_in_transfer = 1'b0;
                n_cur_msg     = '0;
                n_exp_seq     = '0;
                n_fill        = '0;
            end
            go = 1'b1;
            if (!n_in_transfer) begin
                if (i_item.flag_first) begin
                    n_fill        = '0;
                    n_in_transfer = 1'b1;
                    n_exp_seq     = i_item.sequence_id;
                    n_cur_msg     = i_item.message_id;
                    if (i_item.sequence_id != '0) begin
                        n_in_transfer = 1'b0;
                        n_cur_msg     = '0;
                        n_exp_seq     = '0;
                        n_fill        = '0;
                        n_result.drop_reason = DROP_FIRST_SEQ;
                        go = 1'b0;
                    end
                end
            end else if (i_item.message_id != n_cur_msg) begin
                n_in_transfer = 1'b0;
                n_result.drop_reason = DROP_WRONG_MSG;
                go = 1'b0;
            end else begin
                n_exp_seq = n_exp_seq + ID_W'(1);
                if (n_exp_seq != i_item.sequence_id) begin
                    n_in_transfer = 1'b0;
                    n_result.drop_reason = DROP_WRONG_SEQ;
                    go = 1'b0;
                end
            end

            if (go) begin
                fill_w   = W'(n_fill);
                room     = (fill_w <= MAX_W) ? MAX_W - fill_w : '0;
                new_fill = fill_w + pay_w;
                if (room < pay_w) begin
                    n_in_transfer = 1'b0;
                    n_cur_msg     = '0;
                    n_exp_seq     = '0;
                    n_fill        = '0;
                    n_result.reply_action = ACT_FAIL_BIG;
                end else begin
                    n_result.store_enable = 1'b1;
                    n_result.store_offset = fill_w[LEN_W-1:0];
                    n_result.store_length = i_item.payload;
                    if (i_item.flag_last) begin
                        n_result.reply_action   = ACT_COMPLETE;
                        n_result.message_length = new_fill[LEN_W-1:0];
                        n_in_transfer = 1'b0;
                        n_cur_msg     = '0;
                        n_exp_seq     = '0;
                        n_fill        = '0;
                    end else begin
                        n_fill = new_fill[FILL_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_transfer <= 1'b0;
            r_cur_msg     <= '0;
            r_exp_seq     <= '0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (pop) begin
                r_in_transfer <= n_in_transfer;
                r_cur_msg     <= n_cur_msg;
                r_exp_seq     <= n_exp_seq;
                r_fill        <= n_fill;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/frt_checker.sv @@
// Port-level checker for the fragment reassembly tracker, with its bind.
`include "assert_macros.svh"

module frt_checker import frt_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input logic [1:0]       o_reply_action,
    input logic [2:0]       o_drop_reason,
    input logic             o_store_enable,
    input logic [LEN_W-1:0] o_store_offset,
    input logic [LEN_W-1:0] o_store_length,
    input logic [LEN_W-1:0] o_message_length
);

    logic store_clear;
    logic not_complete;
    logic len_clear;
    logic has_drop;
    logic drop_quiet;

    assign store_clear  = (o_store_offset == '0) && (o_store_length == '0);
    assign not_complete = o_reply_action != ACT_COMPLETE;
    assign len_clear    = o_message_length == '0;
    assign has_drop     = o_drop_reason != DROP_NONE;
    assign drop_quiet   = (o_reply_action == ACT_NONE) && !o_store_enable;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    `ASSERT_SAME(a_no_store_zero, i_clk, i_rst_n, o_valid && !o_store_enable, store_clear)

    `ASSERT_SAME(a_len_only_complete, i_clk, i_rst_n, o_valid && not_complete, len_clear)

    `ASSERT_SAME(a_drop_silent, i_clk, i_rst_n, o_valid && has_drop, drop_quiet)

endmodule

bind fragment_reassembly_tracker_unit frt_checker u_frt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_reply_action   (o_reply_action),
    .o_drop_reason    (o_drop_reason),
    .o_store_enable   (o_store_enable),
    .o_store_offset   (o_store_offset),
    .o_store_length   (o_store_length),
    .o_message_length (o_message_length)
);
